// ===== hdl/lprp_pkg.sv =====
// Package for the length-prefixed record parser.
// Holds the beat structs, result kinds, error codes and character constants.
// Used by the parser top level; depends on nothing.
package lprp_pkg;

    localparam int PKT_W = 29;

    typedef struct packed {
        logic [7:0] byte_req;
        logic       restart;
    } lprp_in_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data_byte;
        logic [PKT_W-1:0] record_length;
        logic [2:0]       error_code;
    } lprp_out_t;

    localparam logic [1:0] KIND_BODY       = 2'd0;
    localparam logic [1:0] KIND_RECORD_END = 2'd1;
    localparam logic [1:0] KIND_PACKET_END = 2'd2;
    localparam logic [1:0] KIND_ERROR      = 2'd3;

    localparam logic [2:0] ERR_BAD_START  = 3'd0;
    localparam logic [2:0] ERR_HDR_LONG   = 3'd1;
    localparam logic [2:0] ERR_BAD_TERM   = 3'd2;
    localparam logic [2:0] ERR_TOO_LARGE  = 3'd3;
    localparam logic [2:0] ERR_ARRAY_FORM = 3'd4;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [PKT_W-1:0] MAX_PACKET_RESET = 29'd134217728;

endpackage

// ===== hdl/length_prefixed_record_parser.sv =====
// Top level of the length-prefixed record parser.
// Depends on lprp_pkg and lprp_len_acc.
//
// The parser takes one request byte per beat and gives at most one result beat for it: a
// body byte, a record end with its length, a packet end or an error code. An error is
// sticky until a beat with restart set. The state update and the result are computed in
// the cycle the byte is accepted and the result is held in an output register, so a new
// byte is accepted every cycle while the output side takes results. The user must write
// max_packet_bytes through cfg_we and cfg_wdata only while the parser idles; unchecked.
module length_prefixed_record_parser
    import lprp_pkg::*;
#(
    parameter int LEN_BITS        = 28,
    parameter int HEADER_LINE_MAX = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lprp_in_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output lprp_out_t        out_data,
    input  logic             cfg_we,
    input  logic [PKT_W-1:0] cfg_wdata
);

    localparam int LW  = LEN_BITS + 1;
    localparam int SW  = ((LW > PKT_W) ? LW : PKT_W) + 1;
    localparam int HCW = $clog2(HEADER_LINE_MAX);

    typedef enum logic [2:0] {
        PH_START,
        PH_LINE,
        PH_HDR,
        PH_LINE_CR,
        PH_BODY,
        PH_TERM,
        PH_TERM_CR,
        PH_ERROR
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [LW-1:0]    length_value_reg, length_value_next;
    logic [LW-1:0]    body_remaining_reg, body_remaining_next;
    logic [HCW-1:0]   header_chars_reg, header_chars_next;
    logic             header_digits_done_reg, header_digits_done_next;
    logic [PKT_W-1:0] packet_bytes_reg, packet_bytes_next;
    logic [PKT_W-1:0] max_packet_bytes_reg;
    logic             out_valid_reg, out_valid_next;
    lprp_out_t        out_data_reg, out_data_next;

    logic             accept;
    logic [7:0]       b;
    logic             is_digit;
    logic [LW-1:0]    lv_start;
    logic [LW-1:0]    acc_len;

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign b        = in_data.byte_req;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign lv_start = in_data.restart ? '0 : length_value_reg;

    lprp_len_acc #(
        .LW (LW)
    ) u_len_acc (
        .len_in  (lv_start),
        .digit   (4'(b - CH_ZERO)),
        .len_out (acc_len)
    );

    always_comb
    begin
        phase_t           ph;
        logic [LW-1:0]    lv;
        logic [LW-1:0]    br;
        logic [HCW-1:0]   hc;
        logic             hd;
        logic [PKT_W-1:0] pb;
        logic             rv;
        lprp_out_t        res;
        logic [SW-1:0]    need;

        ph   = phase_reg;
        lv   = length_value_reg;
        br   = body_remaining_reg;
        hc   = header_chars_reg;
        hd   = header_digits_done_reg;
        pb   = packet_bytes_reg;
        rv   = 1'b0;
        res  = '0;
        need = '0;

        if (accept)
        begin
            if (in_data.restart)
            begin
                ph = PH_START;
                lv = '0;
                br = '0;
                hc = '0;
                hd = 1'b0;
                pb = '0;
            end
            if (ph != PH_ERROR)
            begin
                if (pb != {PKT_W{1'b1}})
                    pb = pb + 1'b1;
                need = SW'(pb) + SW'(lv);
                unique case (ph)
                    PH_START, PH_LINE, PH_LINE_CR:
                    begin
                        if (ph == PH_START && (b == CH_LF || b == CH_CR))
                        begin
                            ph = PH_START;
                        end
                        else if (ph == PH_START && b == CH_STAR)
                        begin
                            ph = PH_ERROR;
                            rv = 1'b1;
                            res.kind = KIND_ERROR;
                            res.error_code = ERR_ARRAY_FORM;
                        end
                        else if (ph != PH_START && b == CH_LF)
                        begin
                            ph = PH_START;
                            lv = '0;
                            br = '0;
                            hc = '0;
                            hd = 1'b0;
                            pb = '0;
                            rv = 1'b1;
                            res.kind = KIND_PACKET_END;
                        end
                        else if (ph == PH_LINE && b == CH_CR)
                        begin
                            ph = PH_LINE_CR;
                        end
                        else if (ph == PH_LINE_CR || !is_digit)
                        begin
                            ph = PH_ERROR;
                            rv = 1'b1;
                            res.kind = KIND_ERROR;
                            res.error_code = ERR_BAD_START;
                        end
                        else
                        begin
                            ph = PH_HDR;
                            hc = HCW'(1);
                            hd = 1'b0;
                            lv = LW'(b - CH_ZERO);
                        end
                    end
                    PH_HDR:
                    begin
                        if (b == CH_LF)
                        begin
                            if (need > SW'(max_packet_bytes_reg))
                            begin
                                ph = PH_ERROR;
                                rv = 1'b1;
                                res.kind = KIND_ERROR;
                                res.error_code = ERR_TOO_LARGE;
                            end
                            else
                            begin
                                br = lv;
                                ph = (lv == '0) ? PH_TERM : PH_BODY;
                            end
                        end
                        else
                        begin
                            hc = hc + 1'b1;
                            if (hc >= HCW'(HEADER_LINE_MAX - 1))
                            begin
                                ph = PH_ERROR;
                                rv = 1'b1;
                                res.kind = KIND_ERROR;
                                res.error_code = ERR_HDR_LONG;
                            end
                            else if (!hd && is_digit)
                            begin
                                lv = acc_len;
                            end
                            else
                            begin
                                hd = 1'b1;
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        br = br - 1'b1;
                        if (br == '0)
                            ph = PH_TERM;
                        rv = 1'b1;
                        res.kind = KIND_BODY;
                        res.data_byte = b;
                    end
                    PH_TERM, PH_TERM_CR:
                    begin
                        if (b == CH_LF)
                        begin
                            rv = 1'b1;
                            if (pb > max_packet_bytes_reg)
                            begin
                                ph = PH_ERROR;
                                res.kind = KIND_ERROR;
                                res.error_code = ERR_TOO_LARGE;
                            end
                            else
                            begin
                                ph = PH_LINE;
                                res.kind = KIND_RECORD_END;
                                res.record_length = PKT_W'(SW'(lv));
                                lv = '0;
                                hc = '0;
                                hd = 1'b0;
                            end
                        end
                        else if (ph == PH_TERM && b == CH_CR)
                        begin
                            ph = PH_TERM_CR;
                        end
                        else
                        begin
                            ph = PH_ERROR;
                            rv = 1'b1;
                            res.kind = KIND_ERROR;
                            res.error_code = ERR_BAD_TERM;
                        end
                    end
                    default:
                    begin
                        ph = PH_ERROR;
                    end
                endcase
            end
        end

        phase_next              = ph;
        length_value_next       = lv;
        body_remaining_next     = br;
        header_chars_next       = hc;
        header_digits_done_next = hd;
        packet_bytes_next       = pb;

        if (accept)
            out_valid_next = rv;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
        out_data_next = (accept && rv) ? res : out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg              <= PH_START;
            length_value_reg       <= '0;
            body_remaining_reg     <= '0;
            header_chars_reg       <= '0;
            header_digits_done_reg <= 1'b0;
            packet_bytes_reg       <= '0;
            max_packet_bytes_reg   <= MAX_PACKET_RESET;
            out_valid_reg          <= 1'b0;
            out_data_reg           <= '0;
        end
        else
        begin
            phase_reg              <= phase_next;
            length_value_reg       <= length_value_next;
            body_remaining_reg     <= body_remaining_next;
            header_chars_reg       <= header_chars_next;
            header_digits_done_reg <= header_digits_done_next;
            packet_bytes_reg       <= packet_bytes_next;
            out_valid_reg          <= out_valid_next;
            out_data_reg           <= out_data_next;
            if (cfg_we)
                max_packet_bytes_reg <= cfg_wdata;
        end
    end

    // An error holds until a beat with restart is accepted.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERROR && !(accept && in_data.restart)) |=> phase_reg == PH_ERROR)
        else $error("error state left without restart");

    // A pending error result always belongs to the current error state.
    a_error_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.kind == KIND_ERROR) |-> phase_reg == PH_ERROR)
        else $error("error result pending outside error state");

    // Every byte accepted inside a body gives a body result.
    a_body_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_data.restart && phase_reg == PH_BODY)
            |=> (out_valid_reg && out_data_reg.kind == KIND_BODY))
        else $error("body byte produced no body result");

endmodule

// ===== hdl/lprp_len_acc.sv =====
// Decimal header accumulator: value times ten plus one digit, saturating.
// Pure combinational logic used by the parser top level; no dependencies.
module lprp_len_acc #(
    parameter int LW = 29
) (
    input  logic [LW-1:0] len_in,
    input  logic [3:0]    digit,
    output logic [LW-1:0] len_out
);

    logic [LW+3:0] wide;
    logic [LW+3:0] cap;

    assign cap  = {4'b0, 1'b1, {(LW-1){1'b0}}};
    assign wide = ({4'b0, len_in} << 3) + ({4'b0, len_in} << 1) + {{LW{1'b0}}, digit};
    assign len_out = (wide > cap) ? cap[LW-1:0] : wide[LW-1:0];

endmodule
